// ===== rtl/clpo_pkg.sv =====
// ----------------------------------------------------------------------------
// clpo_pkg
// Shared types and codes of the circular list position unit: action and
// status codes, sequencer states and field widths.
// ----------------------------------------------------------------------------
package clpo_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned ACTION_W     = 3;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned VALUE_W      = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_END   = 3'd1,
    ACT_DEL_FRONT = 3'd2,
    ACT_DEL_END   = 3'd3,
    ACT_INS_AT    = 3'd4,
    ACT_DEL_AT    = 3'd5,
    ACT_SEARCH    = 3'd6
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_INVALID  = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_RD2,
    S_CHK2,
    S_W1,
    S_W2,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_SEARCH,
    OP_INS_EMPTY,
    OP_INS_HEAD,
    OP_INS_TAIL,
    OP_INS_MID,
    OP_DEL_HEAD,
    OP_DEL_MID
  } op_e;

endpackage

// ===== rtl/circular_list_position_ops_unit.sv =====
// ----------------------------------------------------------------------------
// circular_list_position_ops_unit
// Bounded ordered list of signed 32-bit values kept as a circular linked list
// in slot memory, with positional insert, delete and search.
// ----------------------------------------------------------------------------
// One item is worked at a time. Refused actions and deletes of a one-entry
// list go straight to the result; an insert into an empty list writes its
// slot, one at the front or end its slot and then the tail link, and a
// delete of the front reads the head and relinks the tail. An insert inside
// the list at position k walks k-2 links, a delete at k walks k-1 and a
// search up to count-1, each hop a read of both memories and a use of the
// registered data. A new item is taken while the previous result still
// waits on the output register. No clearing pass is needed after reset.
module circular_list_position_ops_unit
  import clpo_pkg::*;
#(
  parameter int unsigned CAPACITY = clpo_pkg::DEF_CAPACITY,
  localparam int unsigned SW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned PW = $clog2(CAPACITY + 2)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic        [clpo_pkg::ACTION_W-1:0] action_i,
  input  logic signed [clpo_pkg::VALUE_W-1:0]  value_i,
  input  logic        [PW-1:0]                 position_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [clpo_pkg::STATUS_W-1:0] status_o,
  output logic        [CW-1:0]                 found_position_o,
  output logic        [CW-1:0]                 count_o
);

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [SW-1:0]       head_q, head_d;
  logic [SW-1:0]       tail_q, tail_d;
  logic [SW-1:0]       cur_q, cur_d;
  logic [SW-1:0]       prv_q, prv_d;
  logic [SW-1:0]       slot_q, slot_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       ctr_q, ctr_d;
  logic [CAPACITY-1:0] free_q, free_d;
  logic [VALUE_W-1:0]  val_q, val_d;
  status_e             res_status_q, res_status_d;
  logic [CW-1:0]       res_found_q, res_found_d;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [CW-1:0]       out_found_q, out_found_d;
  logic [CW-1:0]       out_count_q, out_count_d;

  logic [SW-1:0]       first_free;
  logic [CW-1:0]       dec_idx;
  logic                full, empty;

  logic                ram_re;
  logic                val_we;
  logic                lnk_we;
  logic [SW-1:0]       lnk_waddr;
  logic [SW-1:0]       lnk_wdata;
  logic [VALUE_W-1:0]  rd_val;
  logic [SW-1:0]       rd_lnk;

  clpo_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (slot_q),
    .wdata_i (val_q),
    .re_i    (ram_re),
    .raddr_i (cur_q),
    .rdata_o (rd_val)
  );

  clpo_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_lnk_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .re_i    (ram_re),
    .raddr_i (cur_q),
    .rdata_o (rd_lnk)
  );

  // lowest free slot
  always_comb begin
    first_free = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        first_free = SW'(i);
      end
    end
  end

  assign full  = (cnt_q == CW'(CAPACITY));
  assign empty = (cnt_q == '0);

  // 0-based list index named by the action
  always_comb begin
    unique case (action_i)
      ACT_INS_END:            dec_idx = cnt_q;
      ACT_DEL_END:            dec_idx = cnt_q - CW'(1);
      ACT_INS_AT, ACT_DEL_AT: dec_idx = CW'(position_i - PW'(1));
      default:                dec_idx = '0;
    endcase
  end

  always_comb begin
    logic go_ins;
    logic go_del;
    state_d      = state_q;
    op_d         = op_q;
    head_d       = head_q;
    tail_d       = tail_q;
    cur_d        = cur_q;
    prv_d        = prv_q;
    slot_d       = slot_q;
    cnt_d        = cnt_q;
    ctr_d        = ctr_q;
    free_d       = free_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_count_d  = out_count_q;
    ram_re       = 1'b0;
    val_we       = 1'b0;
    lnk_we       = 1'b0;
    lnk_waddr    = slot_q;
    lnk_wdata    = slot_q;
    in_stall_o   = (state_q != S_IDLE);
    go_ins       = 1'b0;
    go_del       = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d        = value_i;
          res_status_d = ST_OK;
          res_found_d  = '0;
          state_d      = S_DONE;
          unique case (action_i)
            ACT_INS_FRONT, ACT_INS_END: begin
              if (full) res_status_d = ST_FULL;
              else      go_ins = 1'b1;
            end
            ACT_DEL_FRONT, ACT_DEL_END: begin
              if (empty) res_status_d = ST_EMPTY;
              else       go_del = 1'b1;
            end
            ACT_INS_AT: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else if (position_i == '0 ||
                           position_i > PW'(cnt_q) + PW'(1)) begin
                res_status_d = ST_INVALID;
              end else begin
                go_ins = 1'b1;
              end
            end
            ACT_DEL_AT: begin
              if (empty) begin
                res_status_d = ST_EMPTY;
              end else if (position_i == '0 || position_i > PW'(cnt_q)) begin
                res_status_d = ST_INVALID;
              end else begin
                go_del = 1'b1;
              end
            end
            ACT_SEARCH: begin
              if (empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                op_d    = OP_SEARCH;
                cur_d   = head_q;
                ctr_d   = '0;
                state_d = S_RD;
              end
            end
            default: res_status_d = ST_INVALID;
          endcase

          if (go_ins) begin
            slot_d = first_free;
            if (empty) begin
              op_d    = OP_INS_EMPTY;
              state_d = S_W1;
            end else if (dec_idx == '0) begin
              op_d    = OP_INS_HEAD;
              state_d = S_W1;
            end else if (dec_idx == cnt_q) begin
              op_d    = OP_INS_TAIL;
              state_d = S_W1;
            end else begin
              op_d    = OP_INS_MID;
              cur_d   = head_q;
              ctr_d   = dec_idx - CW'(1);
              state_d = S_RD;
            end
          end

          if (go_del) begin
            if (cnt_q == CW'(1)) begin
              free_d[head_q] = 1'b1;
              cnt_d          = '0;
            end else if (dec_idx == '0) begin
              op_d    = OP_DEL_HEAD;
              cur_d   = head_q;
              ctr_d   = '0;
              state_d = S_RD;
            end else begin
              op_d    = OP_DEL_MID;
              cur_d   = head_q;
              ctr_d   = dec_idx - CW'(1);
              state_d = S_RD;
            end
          end
        end
      end

      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_CHK;
      end

      S_CHK: begin
        if (op_q == OP_SEARCH) begin
          if (rd_val == val_q) begin
            res_status_d = ST_OK;
            res_found_d  = ctr_q + CW'(1);
            state_d      = S_DONE;
          end else if (ctr_q + CW'(1) == cnt_q) begin
            res_status_d = ST_NOTFOUND;
            state_d      = S_DONE;
          end else begin
            ctr_d   = ctr_q + CW'(1);
            cur_d   = rd_lnk;
            state_d = S_RD;
          end
        end else if (ctr_q != '0) begin
          ctr_d   = ctr_q - CW'(1);
          cur_d   = rd_lnk;
          state_d = S_RD;
        end else if (op_q == OP_DEL_HEAD) begin
          lnk_we         = 1'b1;
          lnk_waddr      = tail_q;
          lnk_wdata      = rd_lnk;
          head_d         = rd_lnk;
          free_d[cur_q]  = 1'b1;
          cnt_d          = cnt_q - CW'(1);
          state_d        = S_DONE;
        end else if (op_q == OP_DEL_MID) begin
          prv_d   = cur_q;
          cur_d   = rd_lnk;
          state_d = S_RD2;
        end else begin
          state_d = S_W1;
        end
      end

      S_RD2: begin
        ram_re  = 1'b1;
        state_d = S_CHK2;
      end

      S_CHK2: begin
        lnk_we        = 1'b1;
        lnk_waddr     = prv_q;
        lnk_wdata     = rd_lnk;
        free_d[cur_q] = 1'b1;
        cnt_d         = cnt_q - CW'(1);
        if (cur_q == tail_q) tail_d = prv_q;
        state_d       = S_DONE;
      end

      S_W1: begin
        val_we         = 1'b1;
        lnk_we         = 1'b1;
        lnk_waddr      = slot_q;
        free_d[slot_q] = 1'b0;
        case (op_q)
          OP_INS_EMPTY: lnk_wdata = slot_q;
          OP_INS_MID:   lnk_wdata = rd_lnk;
          default:      lnk_wdata = head_q;
        endcase
        if (op_q == OP_INS_EMPTY) begin
          head_d  = slot_q;
          tail_d  = slot_q;
          cnt_d   = cnt_q + CW'(1);
          state_d = S_DONE;
        end else begin
          state_d = S_W2;
        end
      end

      S_W2: begin
        lnk_we    = 1'b1;
        lnk_wdata = slot_q;
        lnk_waddr = (op_q == OP_INS_MID) ? cur_q : tail_q;
        if (op_q == OP_INS_HEAD) head_d = slot_q;
        if (op_q == OP_INS_TAIL) tail_d = slot_q;
        if (op_q == OP_INS_MID && cur_q == tail_q) tail_d = slot_q;
        cnt_d   = cnt_q + CW'(1);
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          out_count_d  = cnt_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      free_q      <= {CAPACITY{1'b1}};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    cur_q        <= cur_d;
    prv_q        <= prv_d;
    slot_q       <= slot_d;
    ctr_q        <= ctr_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_found_q;
  assign count_o          = out_count_q;

endmodule

// ===== rtl/clpo_ram.sv =====
// ----------------------------------------------------------------------------
// clpo_ram
// Generic single write port, single read port memory with registered read
// data. Read data holds until the next read.
// ----------------------------------------------------------------------------
module clpo_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/clpo_chk.sv =====
// ----------------------------------------------------------------------------
// clpo_chk
// Port-level checks of the circular list position unit, bound to the top
// level.
// ----------------------------------------------------------------------------
module clpo_chk #(
  parameter int unsigned CAPACITY = clpo_pkg::DEF_CAPACITY,
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned PW = $clog2(CAPACITY + 2)
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic        [clpo_pkg::ACTION_W-1:0] action_i,
  input logic signed [clpo_pkg::VALUE_W-1:0]  value_i,
  input logic        [PW-1:0]                 position_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic        [clpo_pkg::STATUS_W-1:0] status_o,
  input logic        [CW-1:0]                 found_position_o,
  input logic        [CW-1:0]                 count_o
);
  import clpo_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(found_position_o) && $stable(count_o))
    else $error("result beat changed while stalled");

  // found position only on a successful search and within the list
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_position_o != '0 |->
    status_o == ST_OK && found_position_o <= count_o)
    else $error("found position without match or past count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> count_o == CW'(CAPACITY))
    else $error("full status with list not full");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> count_o == '0)
    else $error("empty status with entries held");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_o <= CW'(CAPACITY) &&
    (status_o == ST_OK || status_o == ST_EMPTY || status_o == ST_INVALID ||
     status_o == ST_FULL || status_o == ST_NOTFOUND))
    else $error("count or status out of range");

endmodule

bind circular_list_position_ops_unit clpo_chk #(.CAPACITY(CAPACITY)) u_clpo_chk (.*);

// ===== tb/circular_list_position_ops_unit_checker.sv =====
// ----------------------------------------------------------------------------
// circular_list_position_ops_unit_checker
// Watches both channels of the circular list unit. Every accepted action beat
// is run through a queue model of the ordered list, and the answer it gives
// is held until the matching result beat comes out, where status, match
// position and entry count are compared one by one.
// ----------------------------------------------------------------------------
module circular_list_position_ops_unit_checker
  import clpo_pkg::*;
#(
  parameter int unsigned CAPACITY = clpo_pkg::DEF_CAPACITY,
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned PW = $clog2(CAPACITY + 2)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic        [ACTION_W-1:0]    action_i,
  input  logic signed [VALUE_W-1:0]     value_i,
  input  logic        [PW-1:0]          position_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic        [STATUS_W-1:0]    status_i,
  input  logic        [CW-1:0]          found_position_i,
  input  logic        [CW-1:0]          count_i,
  output int                            mismatches_o,
  output int                            outstanding_o,
  output int                            held_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [CW-1:0]       found;
    logic [CW-1:0]       count;
  } list_answer_t;

  logic signed [VALUE_W-1:0] entries[$];
  list_answer_t              answers_due[$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches_o++;
  endtask

  function automatic list_answer_t apply_action(input logic [ACTION_W-1:0] act,
                                                input logic signed [VALUE_W-1:0] val,
                                                input logic [PW-1:0] pos);
    list_answer_t ans;
    int           len;
    ans.status = ST_OK;
    ans.found  = '0;
    len = entries.size();
    case (act)
      ACT_INS_FRONT, ACT_INS_END: begin
        if (len >= CAPACITY) begin
          ans.status = ST_FULL;
        end else if (act == ACT_INS_FRONT) begin
          entries.push_front(val);
        end else begin
          entries.push_back(val);
        end
      end
      ACT_DEL_FRONT, ACT_DEL_END: begin
        if (len == 0) begin
          ans.status = ST_EMPTY;
        end else if (act == ACT_DEL_FRONT) begin
          void'(entries.pop_front());
        end else begin
          void'(entries.pop_back());
        end
      end
      ACT_INS_AT: begin
        if (len >= CAPACITY) begin
          ans.status = ST_FULL;
        end else if (pos == 0 || int'(pos) > len + 1) begin
          ans.status = ST_INVALID;
        end else begin
          entries.insert(int'(pos) - 1, val);
        end
      end
      ACT_DEL_AT: begin
        if (len == 0) begin
          ans.status = ST_EMPTY;
        end else if (pos == 0 || int'(pos) > len) begin
          ans.status = ST_INVALID;
        end else begin
          entries.delete(int'(pos) - 1);
        end
      end
      ACT_SEARCH: begin
        if (len == 0) begin
          ans.status = ST_EMPTY;
        end else begin
          ans.status = ST_NOTFOUND;
          for (int i = 0; i < len; i++) begin
            if (entries[i] == val) begin
              ans.status = ST_OK;
              ans.found  = CW'(i + 1);
              break;
            end
          end
        end
      end
      default: ans.status = ST_INVALID;
    endcase
    ans.count = CW'(entries.size());
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_answer_t got;
    if (!rst_ni) begin
      entries.delete();
      answers_due.delete();
      mismatches_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        answers_due.push_back(apply_action(action_i, value_i, position_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result beat with no action outstanding");
        end else begin
          got = answers_due.pop_front();
          if (status_i !== got.status) begin
            report_mismatch($sformatf("status %0d, want %0d", status_i, got.status));
          end
          if (found_position_i !== got.found) begin
            report_mismatch($sformatf("found position %0d, want %0d",
                                      found_position_i, got.found));
          end
          if (count_i !== got.count) begin
            report_mismatch($sformatf("count %0d, want %0d", count_i, got.count));
          end
        end
      end
    end
    outstanding_o = answers_due.size();
    held_o        = entries.size();
  end

endmodule

// ===== tb/circular_list_position_ops_unit_test.sv =====
// ----------------------------------------------------------------------------
// circular_list_position_ops_unit_test
// Drives the circular list unit with a directed pass over the empty, invalid
// position and search cases, then with random bursts that grow, shrink or
// churn the list under three sender and receiver idling mixes. The checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module circular_list_position_ops_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import clpo_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = $clog2(CAPACITY + 2);
  localparam logic [ACTION_W-1:0] ACT_UNDEFINED = 3'd7;
  localparam int BURST_LEN   = 30;
  localparam int DRAIN_WAIT  = 40;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_e;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic        [ACTION_W-1:0] action = '0;
  logic signed [VALUE_W-1:0]  value = '0;
  logic        [PW-1:0]       position = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic        [STATUS_W-1:0] status;
  logic        [CW-1:0]       found_position;
  logic        [CW-1:0]       count;

  int mismatches;
  int outstanding;
  int held;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  circular_list_position_ops_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .action_i        (action),
    .value_i         (value),
    .position_i      (position),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .found_position_o(found_position),
    .count_o         (count)
  );

  circular_list_position_ops_unit_checker #(
    .CAPACITY(CAPACITY)
  ) list_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .action_i        (action),
    .value_i         (value),
    .position_i      (position),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .status_i        (status),
    .found_position_i(found_position),
    .count_i         (count),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding),
    .held_o          (held)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_beat(input logic [ACTION_W-1:0] act,
                           input logic signed [VALUE_W-1:0] val,
                           input logic [PW-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    action   = act;
    value    = val;
    position = pos;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(99) < 50) begin
      case ($urandom_range(7))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return -32'sd1;
        3: return 32'sd0;
        4: return 32'sd1;
        5: return 32'sh5555_5555;
        6: return 32'shaaaa_aaaa;
        default: return 32'sd42;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_random_beat(input mix_e mix);
    int                  r;
    int                  ins_lim;
    int                  del_lim;
    int                  len;
    logic [ACTION_W-1:0] act;
    logic [PW-1:0]       pos;
    len = held;
    r   = $urandom_range(99);
    case (mix)
      MIX_GROW:   begin ins_lim = 75; del_lim = 85; end
      MIX_SHRINK: begin ins_lim = 15; del_lim = 75; end
      default:    begin ins_lim = 40; del_lim = 75; end
    endcase
    if (r < ins_lim) begin
      case ($urandom_range(2))
        0:       act = ACT_INS_FRONT;
        1:       act = ACT_INS_END;
        default: act = ACT_INS_AT;
      endcase
    end else if (r < del_lim) begin
      case ($urandom_range(2))
        0:       act = ACT_DEL_FRONT;
        1:       act = ACT_DEL_END;
        default: act = ACT_DEL_AT;
      endcase
    end else if (r < 98) begin
      act = ACT_SEARCH;
    end else begin
      act = ACT_UNDEFINED;
    end
    pos = PW'($urandom_range(31));
    if (act == ACT_INS_AT && $urandom_range(99) < 85) begin
      pos = PW'($urandom_range(len + 1, 1));
    end else if (act == ACT_DEL_AT && len > 0 && $urandom_range(99) < 85) begin
      pos = PW'($urandom_range(len, 1));
    end
    send_beat(act, pick_value(), pos);
  endtask

  initial begin
    int   phase_items;
    mix_e mix;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle_pct  = 32;
    recv_stall_pct = 61;

    // empty list
    send_beat(ACT_SEARCH,    32'sd0, 5'd0);
    send_beat(ACT_DEL_FRONT, 32'sd0, 5'd0);
    send_beat(ACT_DEL_END,   32'sd0, 5'd0);
    send_beat(ACT_DEL_AT,    32'sd0, 5'd1);
    send_beat(ACT_DEL_AT,    32'sd0, 5'd0);
    send_beat(ACT_INS_AT,    32'sd9, 5'd2);
    send_beat(ACT_INS_AT,    32'sd9, 5'd0);
    send_beat(ACT_INS_AT,    32'sd7, 5'd1);
    // build a short list with the value extremes
    send_beat(ACT_INS_FRONT, 32'sh8000_0000, 5'd0);
    send_beat(ACT_INS_END,   32'sh7fff_ffff, 5'd0);
    send_beat(ACT_INS_AT,    -32'sd1, 5'd4);
    send_beat(ACT_INS_AT,    32'sd0, 5'd2);
    send_beat(ACT_INS_AT,    32'sd5, 5'd7);
    send_beat(ACT_INS_AT,    32'sd5, 5'd31);
    send_beat(ACT_SEARCH,    32'sh7fff_ffff, 5'd0);
    send_beat(ACT_SEARCH,    32'sh8000_0000, 5'd0);
    send_beat(ACT_SEARCH,    32'sd12345, 5'd0);
    send_beat(ACT_DEL_AT,    32'sd0, 5'd0);
    send_beat(ACT_DEL_AT,    32'sd0, 5'd6);
    send_beat(ACT_UNDEFINED, 32'sd0, 5'd0);
    // take it apart again
    send_beat(ACT_DEL_AT,    32'sd0, 5'd5);
    send_beat(ACT_DEL_AT,    32'sd0, 5'd2);
    send_beat(ACT_DEL_AT,    32'sd0, 5'd1);
    send_beat(ACT_DEL_END,   32'sd0, 5'd0);
    send_beat(ACT_DEL_FRONT, 32'sd0, 5'd0);

    for (int phase = 0; phase < 3; phase++) begin
      drain_results();
      case (phase)
        0:       begin send_idle_pct = 32; recv_stall_pct = 61; end
        1:       begin send_idle_pct = 61; recv_stall_pct = 32; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      phase_items = (phase == 2) ? 380 : 360;
      mix = MIX_GROW;
      for (int n = 0; n < phase_items; n++) begin
        if (n == phase_items / 2) drain_results();
        if (n % BURST_LEN == 0) begin
          mix = mix_e'($urandom_range(2));
          if (n == 0) mix = MIX_GROW;
        end
        send_random_beat(mix);
      end
    end

    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/clpo_pkg.sv
rtl/clpo_ram.sv
rtl/circular_list_position_ops_unit.sv
rtl/clpo_chk.sv
tb/circular_list_position_ops_unit_checker.sv
tb/circular_list_position_ops_unit_test.sv
